// File: rtl/core/rtrw_pkg.sv
// ----------------------------------------------------------------------------
// rtrw_pkg
// Shared types and constants for the rotor-table random word generator.
// ----------------------------------------------------------------------------
package rtrw_pkg;

  localparam int unsigned NIB_W        = 4;
  localparam int unsigned LANES        = 16;
  localparam int unsigned WORD_W       = NIB_W * LANES;   // 64
  localparam int unsigned TBL_ADDR_W   = 2 * NIB_W;       // row, col
  localparam int unsigned TBL_DEPTH    = 1 << TBL_ADDR_W; // 256

  localparam int unsigned IN_TDATA_W   = 80;
  localparam int unsigned OUT_TDATA_W  = 72;

  // default queue depths
  localparam int unsigned CMD_DEPTH_DEF = 2;
  localparam int unsigned OUT_DEPTH_DEF = 4;

  // request codes as carried on the input stream
  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_SEED = 2'd1,
    MODE_GEN  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_SEED,
    CMD_GEN
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [NIB_W-1:0]    row;
    logic [NIB_W-1:0]    col;
    logic [NIB_W-1:0]    value;
    logic [WORD_W-1:0]   seed;
  } cmd_t;

  typedef struct packed {
    logic                seeded;
    logic [WORD_W-1:0]   random_word;
  } res_t;

endpackage

// File: rtl/core/rtrw_fifo.sv
// ----------------------------------------------------------------------------
// rtrw_fifo
// Small register queue with occupancy count; used for commands and results.
// ----------------------------------------------------------------------------
module rtrw_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [WIDTH-1:0]             wdata_i,
  input  logic                         pop_i,
  output logic                         valid_o,
  output logic [WIDTH-1:0]             rdata_o,
  output logic                         full_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign count_o = cnt_q;
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: rtl/core/rtrw_front.sv
// ----------------------------------------------------------------------------
// rtrw_front
// Accepts input requests, unpacks the fields and classifies the mode.
// ----------------------------------------------------------------------------
module rtrw_front (
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [rtrw_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                             q_full_i,
  output logic                             q_push_o,
  output rtrw_pkg::cmd_t                   q_cmd_o
);

  import rtrw_pkg::*;

  mode_e mode;
  logic  keep;

  assign mode          = mode_e'(s_axis_tdata[1:0]);
  assign s_axis_tready = !q_full_i;

  always_comb begin
    q_cmd_o.row   = s_axis_tdata[5:2];
    q_cmd_o.col   = s_axis_tdata[9:6];
    q_cmd_o.value = s_axis_tdata[13:10];
    q_cmd_o.seed  = s_axis_tdata[77:14];
    q_cmd_o.kind  = CMD_LOAD;
    keep          = 1'b1;
    unique case (mode)
      MODE_LOAD: q_cmd_o.kind = CMD_LOAD;
      MODE_SEED: q_cmd_o.kind = CMD_SEED;
      MODE_GEN:  q_cmd_o.kind = CMD_GEN;
      default:   keep = 1'b0;   // unused code: taken and dropped
    endcase
  end

  assign q_push_o = s_axis_tvalid && s_axis_tready && keep;

endmodule

// File: rtl/core/rtrw_back.sv
// ----------------------------------------------------------------------------
// rtrw_back
// Executes commands: table loads, seeding and word generation.
// ----------------------------------------------------------------------------
module rtrw_back #(
  parameter int unsigned OUT_DEPTH = rtrw_pkg::OUT_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cmd_valid_i,
  input  rtrw_pkg::cmd_t                     cmd_i,
  output logic                               cmd_pop_o,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]     out_count_i,
  output logic                               res_push_o,
  output rtrw_pkg::res_t                     res_o
);

  import rtrw_pkg::*;

  localparam int unsigned CntW = $clog2(OUT_DEPTH + 1);

  logic [WORD_W-1:0] a_q, b_q;        // rows set by seed
  logic              from_gen_q;      // rows follow last lookup
  logic              seed_nz_q;
  logic              pend_q;          // lookup data waits to be queued
  logic              seeded_q;

  logic [NIB_W-1:0]  pre_nib_q [LANES];
  logic [NIB_W-1:0]  aux_nib_q [LANES];
  logic [WORD_W-1:0] pre_w, aux_w, num_w;
  logic [WORD_W-1:0] a_gen, b_gen, a_eff, b_eff, seed_rev;

  logic              room;
  logic              load_en, seed_en, gen_en;
  logic [CntW:0]     occ;

  // pack lookup nibbles and derive the rows they imply
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      pre_w[i*NIB_W +: NIB_W] = pre_nib_q[i];
      aux_w[i*NIB_W +: NIB_W] = aux_nib_q[i];
    end
    num_w = pre_w ^ aux_w;
    for (int i = 0; i < LANES; i++) begin
      a_gen[i*NIB_W +: NIB_W]    = num_w[(LANES-1-i)*NIB_W +: NIB_W];
      seed_rev[i*NIB_W +: NIB_W] = cmd_i.seed[(LANES-1-i)*NIB_W +: NIB_W];
    end
    b_gen = aux_w;
  end

  assign a_eff = from_gen_q ? a_gen : a_q;
  assign b_eff = from_gen_q ? b_gen : b_q;

  // a generate only goes when its result is sure of a slot
  assign occ       = (CntW + 1)'(out_count_i) + (CntW + 1)'(pend_q);
  assign room      = (occ < (CntW + 1)'(OUT_DEPTH));
  assign cmd_pop_o = cmd_valid_i && ((cmd_i.kind != CMD_GEN) || room);

  assign load_en = cmd_pop_o && (cmd_i.kind == CMD_LOAD);
  assign seed_en = cmd_pop_o && (cmd_i.kind == CMD_SEED);
  assign gen_en  = cmd_pop_o && (cmd_i.kind == CMD_GEN);

  // one table copy per lane, two read ports each
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    localparam int unsigned PA = k;
    localparam int unsigned PB = LANES - 1 - k;
    localparam int unsigned QB = (k + LANES - 1) % LANES;
    localparam int unsigned QA = (LANES + 17 - k) % LANES;

    logic [NIB_W-1:0]      mem_q [TBL_DEPTH];
    logic [TBL_ADDR_W-1:0] addr_p, addr_x;

    assign addr_p = {a_eff[PA*NIB_W +: NIB_W], b_eff[PB*NIB_W +: NIB_W]};
    assign addr_x = {b_eff[QB*NIB_W +: NIB_W], a_eff[QA*NIB_W +: NIB_W]};

    always_ff @(posedge clk_i) begin
      if (load_en) begin
        mem_q[{cmd_i.row, cmd_i.col}] <= cmd_i.value;
      end
      if (gen_en) begin
        pre_nib_q[k] <= mem_q[addr_p];
        aux_nib_q[k] <= mem_q[addr_x];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q        <= '0;
      b_q        <= '0;
      from_gen_q <= 1'b0;
      seed_nz_q  <= 1'b0;
      pend_q     <= 1'b0;
    end else begin
      pend_q <= gen_en;
      if (seed_en) begin
        a_q        <= cmd_i.seed;
        b_q        <= seed_rev;
        from_gen_q <= 1'b0;
        seed_nz_q  <= (cmd_i.seed != '0);
      end else if (gen_en) begin
        from_gen_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (gen_en) begin
      seeded_q <= seed_nz_q;
    end
  end

  assign res_push_o        = pend_q;
  assign res_o.random_word = num_w;
  assign res_o.seeded      = seeded_q;

endmodule

// File: rtl/core/rotor_table_random_word_generator.sv
// ----------------------------------------------------------------------------
// rotor_table_random_word_generator
// Rotor-table word generator: 16x16 table of 4-bit entries, two position
// rows, one 64-bit word per generate request.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload (tdata, lowest bit up)
//  ---------+-----+------------------------------------------------------------
//  s_axis   | in  | mode[1:0] entry_row[5:2] entry_col[9:6] entry_value[13:10]
//           |     | seed_value[77:14], zero pad [79:78]
//  m_axis   | out | random_word[63:0] seeded[64], zero pad [71:65]
//
//  Cycles: one request per cycle sustained while the result queue has a free
//  slot, any mix of load, seed and generate. A generate reads the table in the
//  cycle it leaves the command queue and its word enters the result queue the
//  cycle after.
//  The limit is the position feedback: the next generate addresses the table
//  straight from the registered lookup data of the last one.
//  Reset: queues empty, position rows zero, seeded flag clear. The table has
//  no reset; entries are undefined until loaded.
//  Stalls: the front stalls only when the command queue is full; the back
//  holds a generate while the result queue has no free slot.
//
module rotor_table_random_word_generator #(
  parameter int unsigned CMD_DEPTH = rtrw_pkg::CMD_DEPTH_DEF,  // command queue depth
  parameter int unsigned OUT_DEPTH = rtrw_pkg::OUT_DEPTH_DEF   // result queue depth, >= 3
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [rtrw_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // mode, entry_row,
                                                              // entry_col, entry_value,
                                                              // seed_value
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [rtrw_pkg::OUT_TDATA_W-1:0]    m_axis_tdata    // random_word, seeded
);

  import rtrw_pkg::*;

  localparam int unsigned CmdW    = $bits(cmd_t);
  localparam int unsigned ResW    = $bits(res_t);
  localparam int unsigned CmdCntW = $clog2(CMD_DEPTH + 1);
  localparam int unsigned OutCntW = $clog2(OUT_DEPTH + 1);

  // front to command queue
  logic               q_push;
  cmd_t               q_cmd;
  logic               q_full;

  // command queue to back
  logic               cq_valid;
  logic [CmdW-1:0]    cq_rdata;
  logic               cq_pop;
  logic [CmdCntW-1:0] cq_count;    // occupancy, not needed by the front

  // back to result queue
  logic               res_push;
  res_t               res;
  logic               oq_full;     // credit scheme keeps this low on push
  logic [OutCntW-1:0] oq_count;
  logic [ResW-1:0]    oq_rdata;

  rtrw_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_cmd_o       (q_cmd)
  );

  rtrw_fifo #(
    .WIDTH (CmdW),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_cmd),
    .pop_i   (cq_pop),
    .valid_o (cq_valid),
    .rdata_o (cq_rdata),
    .full_o  (q_full),
    .count_o (cq_count)
  );

  rtrw_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cq_valid),
    .cmd_i       (cmd_t'(cq_rdata)),
    .cmd_pop_o   (cq_pop),
    .out_count_i (oq_count),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  // result queue doubles as the output register
  rtrw_fifo #(
    .WIDTH (ResW),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push && !oq_full),
    .wdata_i (res),
    .pop_i   (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .rdata_o (oq_rdata),
    .full_o  (oq_full),
    .count_o (oq_count)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - ResW)'(cq_count & '0), oq_rdata};

endmodule

// File: sim/rotor_table_random_word_generator_checker.sv
// ----------------------------------------------------------------------------
// rotor_table_random_word_generator_checker
// Watches both streams, keeps its own copy of rotor table and position rows,
// predicts every generated word and compares it with what the block returns.
// ----------------------------------------------------------------------------
module rotor_table_random_word_generator_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             req_valid_i,
  input  logic                             req_ready_i,
  input  logic [rtrw_pkg::IN_TDATA_W-1:0]  req_data_i,    // mode, row, col, value, seed
  input  logic                             word_valid_i,
  input  logic                             word_ready_i,
  input  logic [rtrw_pkg::OUT_TDATA_W-1:0] word_data_i,   // random_word, seeded
  output int unsigned                      mismatches_o,
  output int unsigned                      words_owed_o
);

  import rtrw_pkg::*;

  logic [NIB_W-1:0] rotor_mem [TBL_DEPTH];
  logic [NIB_W-1:0] row_a [LANES];
  logic [NIB_W-1:0] row_b [LANES];
  logic             seeded_q;
  res_t             owed_words [$];

  // Apply one accepted request to the shadow state; a generate queues its word.
  task automatic apply_request(input logic [IN_TDATA_W-1:0] req);
    logic [WORD_W-1:0] seed;
    logic [WORD_W-1:0] pre;
    logic [WORD_W-1:0] aux;
    logic [WORD_W-1:0] word;
    logic [NIB_W-1:0]  k4;
    res_t              res;
    int                k;
    case (mode_e'(req[1:0]))
      MODE_LOAD: rotor_mem[{req[5:2], req[9:6]}] = req[13:10];
      MODE_SEED: begin
        seed = req[77:14];
        for (k = 0; k < LANES; k++) begin
          row_a[k] = seed[4*k +: 4];
          row_b[k] = seed[4*(15-k) +: 4];
        end
        seeded_q = |seed;
      end
      MODE_GEN: begin
        for (k = 0; k < LANES; k++) begin
          k4 = k[3:0];
          pre[4*k +: 4] = rotor_mem[{row_a[k4], row_b[4'd15 - k4]}];
          // lane k of aux uses B one lane down and A at lane 1 - k, modulo 16
          aux[4*k +: 4] = rotor_mem[{row_b[k4 - 4'd1], row_a[4'd1 - k4]}];
        end
        word = pre ^ aux;
        for (k = 0; k < LANES; k++) begin
          row_a[k] = word[4*(15-k) +: 4];
          row_b[k] = aux[4*k +: 4];
        end
        res.random_word = word;
        res.seeded      = seeded_q;
        owed_words.push_back(res);
      end
      default: ;  // spare code, ignored
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    res_t want;
    int   k;
    if (!rst_ni) begin
      for (k = 0; k < LANES; k++) begin
        row_a[k] = '0;
        row_b[k] = '0;
      end
      seeded_q = 1'b0;
      owed_words.delete();
      mismatches_o = 0;
      words_owed_o = 0;
    end else begin
      if (word_valid_i && word_ready_i) begin
        if (owed_words.size() == 0) begin
          $error("random_word: none expected, got %h", word_data_i[WORD_W-1:0]);
          mismatches_o++;
        end else begin
          want = owed_words.pop_front();
          if (word_data_i[WORD_W-1:0] !== want.random_word) begin
            $error("random_word: expected %h, got %h", want.random_word,
                   word_data_i[WORD_W-1:0]);
            mismatches_o++;
          end
          if (word_data_i[WORD_W] !== want.seeded) begin
            $error("seeded: expected %b, got %b", want.seeded, word_data_i[WORD_W]);
            mismatches_o++;
          end
        end
      end
      if (req_valid_i && req_ready_i) apply_request(req_data_i);
      words_owed_o = owed_words.size();
    end
  end

endmodule

// File: sim/rotor_table_random_word_generator_tb.sv
// ----------------------------------------------------------------------------
// rotor_table_random_word_generator_tb
// Drives load, seed, generate and spare requests with random gaps and
// back-pressure; a separate checker predicts and compares every word.
// ----------------------------------------------------------------------------
module rotor_table_random_word_generator_tb;
  import rtrw_pkg::*;

  localparam logic [1:0]  MODE_SPARE  = 2'd3;   // unused code, must be ignored
  localparam int unsigned STALL_LIMIT = 2000;   // cycles with no handshake at all
  localparam int unsigned HOLD_AT     = 200;    // words taken before the long hold
  localparam int unsigned HOLD_CYCLES = 80;     // long enough to fill both queues
  localparam int unsigned MIXED_ITEMS = 1270;
  localparam int unsigned TAIL_CYCLES = 8;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // mode, entry_row, entry_col, entry_value,
                                          // seed_value
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // random_word, seeded
  int unsigned            mismatches;
  int unsigned            words_owed;
  bit                     steady = 1'b0;  // while set neither side idles

  rotor_table_random_word_generator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  rotor_table_random_word_generator_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_i  (s_axis_tready),
    .req_data_i   (s_axis_tdata),
    .word_valid_i (m_axis_tvalid),
    .word_ready_i (m_axis_tready),
    .word_data_i  (m_axis_tdata),
    .mismatches_o (mismatches),
    .words_owed_o (words_owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [IN_TDATA_W-1:0] pack_request(
    input logic [1:0]        mode,
    input logic [NIB_W-1:0]  row,
    input logic [NIB_W-1:0]  col,
    input logic [NIB_W-1:0]  value,
    input logic [WORD_W-1:0] seed
  );
    return {2'b00, seed, value, col, row, mode};
  endfunction

  // Offer one request after a random gap and hold it until taken. With no gap
  // tvalid simply stays high, so it is never dropped and raised in one step.
  task automatic push_request(input logic [IN_TDATA_W-1:0] req);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic logic [WORD_W-1:0] draw_seed();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       return '0;
      1:       return '1;
      2:       return 64'hF << (4 * $urandom_range(0, 15));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Result side: random stalls, plus one long hold so the block backs up
  // all the way to its request input.
  initial begin : drain
    int unsigned taken;
    int unsigned gap;
    bit          held;
    taken = 0;
    held  = 1'b0;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 5);
      if (!held && taken == HOLD_AT) begin
        gap  = HOLD_CYCLES;
        held = 1'b1;
      end
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      taken++;
    end
  end

  // Ends the run if neither stream moves for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [7:0]  order [TBL_DEPTH];
    logic [7:0]  swap;
    int unsigned j;
    int unsigned n;
    int unsigned pick;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Every generate here only reads entries already loaded.
    push_request(pack_request(MODE_LOAD, 4'h0, 4'h0, 4'h0, '0));
    push_request(pack_request(MODE_SPARE, 4'hF, 4'hF, 4'hF, '1));  // ignored
    push_request(pack_request(MODE_GEN, 4'h0, 4'h0, 4'h0, '0));    // before any seed
    push_request(pack_request(MODE_LOAD, 4'hF, 4'hF, 4'hF, '0));
    push_request(pack_request(MODE_LOAD, 4'h0, 4'hF, 4'h5, '0));
    push_request(pack_request(MODE_LOAD, 4'hF, 4'h0, 4'h5, '0));
    push_request(pack_request(MODE_SEED, 4'h0, 4'h0, 4'h0, '1));   // rows all F
    push_request(pack_request(MODE_GEN, 4'h0, 4'h0, 4'h0, '0));    // A -> 0, B -> F
    push_request(pack_request(MODE_GEN, 4'h0, 4'h0, 4'h0, '0));    // reads 0,F and F,0
    push_request(pack_request(MODE_SEED, 4'h0, 4'h0, 4'h0, '0));   // seeded flag clears
    push_request(pack_request(MODE_GEN, 4'h0, 4'h0, 4'h0, '0));
    push_request(pack_request(MODE_SEED, 4'h0, 4'h0, 4'h0, 64'hF000_0000_0000_0000));
    push_request(pack_request(MODE_GEN, 4'h0, 4'h0, 4'h0, '0));
    push_request(pack_request(MODE_SEED, 4'h0, 4'h0, 4'h0, 64'h1));
    push_request(pack_request(MODE_SPARE, 4'h0, 4'h0, 4'h0, '0));

    // Fill every table entry in shuffled order before any further generate.
    for (j = 0; j < TBL_DEPTH; j++) order[j] = j[7:0];
    for (j = TBL_DEPTH - 1; j > 0; j--) begin
      n        = $urandom_range(0, j);
      swap     = order[j];
      order[j] = order[n];
      order[n] = swap;
    end
    for (j = 0; j < TBL_DEPTH; j++)
      push_request(pack_request(MODE_LOAD, order[j][7:4], order[j][3:0],
                                4'($urandom), '0));

    // Mixed traffic, mostly generates; one stretch runs with no idling.
    for (n = 0; n < MIXED_ITEMS; n++) begin
      steady = (n >= 400 && n < 550);
      pick   = $urandom_range(0, 99);
      if (pick < 60)
        push_request(pack_request(MODE_GEN, 4'($urandom), 4'($urandom),
                                  4'($urandom), {$urandom, $urandom}));
      else if (pick < 80)
        push_request(pack_request(MODE_LOAD, 4'($urandom), 4'($urandom),
                                  4'($urandom), {$urandom, $urandom}));
      else if (pick < 95)
        push_request(pack_request(MODE_SEED, 4'($urandom), 4'($urandom),
                                  4'($urandom), draw_seed()));
      else
        push_request(pack_request(MODE_SPARE, 4'($urandom), 4'($urandom),
                                  4'($urandom), {$urandom, $urandom}));
    end
    steady = 1'b0;
    s_axis_tvalid <= 1'b0;

    // Let the last request reach the checker, then drain all owed words.
    @(posedge clk_i);
    while (words_owed != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
